/* rtl/tlsi_pkg.sv */
// ----------------------------------------------------------------------------
// tlsi_pkg: shared types and codes of the line start index
// Word layouts of both channels, operation modes, status codes and the
// newline code unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tlsi_pkg;

  localparam int MODE_W   = 3;
  localparam int CHAR_W   = 16;
  localparam int POS_W    = 20;
  localparam int ARG_W    = 13;
  localparam int STATUS_W = 2;
  localparam int LNUM_W   = 12;
  localparam int LCNT_W   = 13;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  position;
    logic [ARG_W-1:0]  line_arg;
  } tlsi_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    line_start;
    logic [POS_W-1:0]    line_end;
    logic [LNUM_W-1:0]   line_number;
    logic [LCNT_W-1:0]   lines_now;
  } tlsi_out_t;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TRIM   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RANGE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 16'd10;

endpackage

`default_nettype wire

/* rtl/tlsi_core.sv */
// ----------------------------------------------------------------------------
// tlsi_core: sequencer and line start table
// Holds the ring of biased line starts in a synchronous RAM, the index
// registers, and the state machine that runs each operation, including the
// binary search of the offset lookup at one table read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsi_core
  import tlsi_pkg::*;
#(
  parameter int MAX_LINES   = 4096,
  parameter int OFFSET_BITS = 20
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           busy_o,
  input  wire tlsi_in_t  in_data_i,
  output logic           res_valid_o,
  input  wire logic      res_ready_i,
  output tlsi_out_t      res_data_o
);

  localparam int LW = $clog2(MAX_LINES);
  localparam int TW = $clog2(MAX_LINES + 1);
  localparam int OW = OFFSET_BITS;
  localparam int AW = (TW > ARG_W) ? TW : ARG_W;
  localparam int PW = (OW > POS_W) ? OW : POS_W;
  localparam logic [TW:0]   SUM_MAX  = (TW + 1)'(MAX_LINES);
  localparam logic [TW-1:0] LINE_MAX = TW'(MAX_LINES);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_TRIM, S_RNG0, S_RNG1, S_SRCH, S_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [LW-1:0]   head_q, head_d;
  logic [TW-1:0]   total_q, total_d;
  logic [OW-1:0]   len_q, len_d;
  logic [OW-1:0]   base_q, base_d;
  tlsi_out_t       res_q, res_d;

  tlsi_in_t        item_q, item_d;
  logic [TW-1:0]   i_q, i_d;
  logic [LW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [OW-1:0]   off_q, off_d;

  logic [OW-1:0]   table_mem [MAX_LINES];
  logic [OW-1:0]   rd_data_q;
  logic [LW-1:0]   rd_addr;
  logic            wr_en;
  logic [LW-1:0]   wr_addr;
  logic [OW-1:0]   wr_data;

  logic [TW-1:0]   arg_line;
  logic            arg_ge;
  logic [TW-1:0]   clamp_i;
  logic [OW-1:0]   clamp_off;
  logic [OW-1:0]   rd_start;
  logic [OW-1:0]   len_inc;
  logic [TW-1:0]   i_inc;
  logic            is_newline;
  logic            srch_le;
  logic [LW-1:0]   lo_n, hi_n;

  // Ring position of a line: one compare and subtract, since the sum stays
  // below twice the depth.
  function automatic logic [LW-1:0] slot_of(input logic [LW-1:0] head,
                                            input logic [TW-1:0] line);
    logic [TW:0] sum;
    sum = (TW + 1)'(head) + (TW + 1)'(line);
    if (sum >= SUM_MAX) begin
      sum = sum - SUM_MAX;
    end
    return sum[LW-1:0];
  endfunction

  function automatic logic [LW-1:0] mid_of(input logic [LW-1:0] lo,
                                           input logic [LW-1:0] hi);
    logic [TW-1:0] span;
    span = TW'(hi) - TW'(lo) + TW'(1);
    return lo + LW'(span >> 1);
  endfunction

  assign arg_line   = TW'(item_q.line_arg);
  assign arg_ge     = AW'(item_q.line_arg) >= AW'(total_q);
  assign clamp_i    = arg_ge ? (total_q - TW'(1)) : arg_line;
  assign clamp_off  = (PW'(item_q.position) > PW'(len_q)) ? len_q : OW'(item_q.position);
  assign rd_start   = rd_data_q - base_q;
  assign len_inc    = len_q + OW'(1);
  assign i_inc      = i_q + TW'(1);
  assign is_newline = item_q.char_code == NEWLINE_CODE;
  assign srch_le    = rd_start <= off_q;
  assign lo_n       = srch_le ? mid_q : lo_q;
  assign hi_n       = srch_le ? hi_q : (mid_q - LW'(1));

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    total_d = total_q;
    len_d   = len_q;
    base_d  = base_q;
    res_d   = res_q;
    item_d  = item_q;
    i_d     = i_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    off_d   = off_q;
    wr_en   = 1'b0;
    wr_addr = slot_of(head_q, total_q);
    wr_data = len_inc + base_q;
    rd_addr = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d        = '0;
        res_d.status = STATUS_OK;
        state_d      = S_DONE;
        case (item_q.mode)
          MODE_CLEAR: begin
            head_d  = '0;
            total_d = TW'(1);
            len_d   = '0;
            base_d  = '0;
          end
          MODE_APPEND: begin
            if (PW'(item_q.position) != PW'(len_q)) begin
              res_d.status = STATUS_MISMATCH;
            end else if ((&len_q) || (is_newline && (total_q == LINE_MAX))) begin
              res_d.status = STATUS_FULL;
            end else begin
              len_d = len_inc;
              if (is_newline) begin
                wr_en   = 1'b1;
                total_d = total_q + TW'(1);
              end
            end
          end
          MODE_TRIM: begin
            if (item_q.line_arg == '0) begin
              state_d = S_DONE;
            end else if (arg_ge) begin
              head_d  = '0;
              total_d = TW'(1);
              len_d   = '0;
              base_d  = '0;
            end else begin
              rd_addr = slot_of(head_q, arg_line);
              state_d = S_TRIM;
            end
          end
          MODE_RANGE: begin
            i_d     = clamp_i;
            rd_addr = slot_of(head_q, clamp_i);
            state_d = S_RNG0;
          end
          MODE_FIND: begin
            off_d = clamp_off;
            lo_d  = '0;
            hi_d  = LW'(total_q - TW'(1));
            if (hi_d != '0) begin
              mid_d   = mid_of('0, hi_d);
              rd_addr = slot_of(head_q, TW'(mid_d));
              state_d = S_SRCH;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_TRIM: begin
        base_d  = base_q + rd_start;
        head_d  = slot_of(head_q, arg_line);
        total_d = total_q - arg_line;
        len_d   = len_q - rd_start;
        state_d = S_DONE;
      end
      S_RNG0: begin
        // Line zero starts at zero and has no table entry of its own.
        res_d.line_start = (i_q == '0) ? '0 : POS_W'(rd_start);
        rd_addr          = slot_of(head_q, i_inc);
        state_d          = S_RNG1;
      end
      S_RNG1: begin
        res_d.line_end = (i_inc < total_q) ? POS_W'(rd_start - OW'(1)) : POS_W'(len_q);
        state_d        = S_DONE;
      end
      S_SRCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d   = mid_of(lo_n, hi_n);
          rd_addr = slot_of(head_q, TW'(mid_d));
        end else begin
          res_d.line_number = LNUM_W'(lo_n);
          state_d           = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if ((state_d == S_DONE) && (state_q != S_DONE)) begin
      res_d.lines_now = LCNT_W'(total_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      total_q <= TW'(1);
      len_q   <= '0;
      base_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      total_q <= total_d;
      len_q   <= len_d;
      base_q  <= base_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    i_q    <= i_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    off_q  <= off_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= table_mem[rd_addr];
  end

  assign busy_o      = state_q != S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_data_o  = res_q;

endmodule

`default_nettype wire

/* rtl/text_line_start_index_top.sv */
// ----------------------------------------------------------------------------
// text_line_start_index_top: line start index over a growing UTF-16 text
// Sequencer with its line start RAM, followed by the output word register.
//
//   channel | direction | handshake                | word
//   in      | input     | in_valid_i / in_stall_o  | in_data_i  (tlsi_in_t)
//   out     | output    | out_valid_o / out_stall_i| out_data_o (tlsi_out_t)
//
// One word is worked on at a time. Line range makes two RAM reads, and the
// offset lookup makes one RAM read per search step.
// After reset the index holds one empty line; the RAM is not cleared.
// A new input word is taken while the previous result still waits on out_stall_i.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_start_index_top
  import tlsi_pkg::*;
#(
  parameter int MAX_LINES   = 4096,
  parameter int OFFSET_BITS = 20
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire tlsi_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output tlsi_out_t      out_data_o
);

  logic      busy;
  logic      res_valid;
  logic      res_ready;
  tlsi_out_t res_data;
  logic      out_valid_q, out_valid_d;
  tlsi_out_t out_data_q;

  tlsi_core #(
    .MAX_LINES   (MAX_LINES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .busy_o      (busy),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data)
  );

  // The output register frees as its word leaves, so a result moves in
  // the same cycle the previous one is taken.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
